/* rtl/amsc_pkg.sv */
`default_nettype none

package amsc_pkg;

  localparam int unsigned NUM_VOLUMES = 4;
  localparam int unsigned VOL_W       = 16;
  localparam int unsigned ACC_W       = 36;
  localparam int unsigned PAW         = 4;

  localparam logic [VOL_W-1:0] VOL_RESET = 16'd16384;

  localparam logic signed [ACC_W-1:0] ACC_MAX  = 36'sh7_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN  = -ACC_MAX - 36'sd1;
  localparam logic signed [ACC_W-1:0] CLIP_POS = 36'sd671088640;
  localparam logic signed [ACC_W-1:0] CLIP_NEG = -CLIP_POS;

  localparam logic [15:0] CLIP_OUT = 16'd32255;
  localparam logic signed [15:0] OUT_MAX = 16'sd32255;
  localparam logic signed [15:0] OUT_MIN = -16'sd32255;

  localparam logic [24:0] K11        = 25'd18454938;
  localparam logic [24:0] K02        = 25'd3355443;
  localparam logic [24:0] FULL_SCALE = 25'd32767;

  typedef logic [VOL_W-1:0] vol_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PROD,
    OP_ACC,
    OP_ABS,
    OP_SQ,
    OP_CUBE,
    OP_LIN,
    OP_CUB2,
    OP_SUB,
    OP_SCALE,
    OP_FIN
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_ACC,
    ST_ABS,
    ST_SQ,
    ST_CUBE,
    ST_LIN,
    ST_CUB2,
    ST_SUB,
    ST_SCALE,
    ST_FIN
  } state_e;

  typedef struct packed {
    op_e  op;
    logic side;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/amsc_if.sv */
`default_nettype none

interface amsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  channel;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic        last_channel;

  modport source (output valid, output channel, output left_sample, output right_sample,
                  output last_channel, input ready);
  modport sink   (input valid, input channel, input left_sample, input right_sample,
                  input last_channel, output ready);
endinterface

interface amsc_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

/* rtl/amsc_regs.sv */
`default_nettype none

module amsc_regs (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [amsc_pkg::PAW-1:0]     paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output amsc_pkg::vol_t [amsc_pkg::NUM_VOLUMES-1:0] vol_o
);

  amsc_pkg::vol_t [amsc_pkg::NUM_VOLUMES-1:0] vol_q, vol_d;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = {16'd0, vol_q[idx]};
  assign vol_o  = vol_q;

  always_comb begin
    vol_d = vol_q;
    if (wr_en) begin
      vol_d[idx] = pwdata[amsc_pkg::VOL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(amsc_pkg::NUM_VOLUMES); i++) begin
        vol_q[i] <= amsc_pkg::VOL_RESET;
      end
    end else begin
      vol_q <= vol_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/amsc_ctrl.sv */
`default_nettype none

module amsc_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  amsc_pkg::sts_t       sts_i,
  output amsc_pkg::cmd_t       cmd_o
);

  amsc_pkg::state_e state_q, state_d;
  logic             side_q, side_d;

  // next state
  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    unique case (state_q)
      amsc_pkg::ST_IDLE:  if (in_valid_i) state_d = amsc_pkg::ST_PROD;
      amsc_pkg::ST_PROD:  state_d = amsc_pkg::ST_ACC;
      amsc_pkg::ST_ACC:   state_d = sts_i.last ? amsc_pkg::ST_ABS : amsc_pkg::ST_IDLE;
      amsc_pkg::ST_ABS:   state_d = amsc_pkg::ST_SQ;
      amsc_pkg::ST_SQ:    state_d = amsc_pkg::ST_CUBE;
      amsc_pkg::ST_CUBE:  state_d = amsc_pkg::ST_LIN;
      amsc_pkg::ST_LIN:   state_d = amsc_pkg::ST_CUB2;
      amsc_pkg::ST_CUB2:  state_d = amsc_pkg::ST_SUB;
      amsc_pkg::ST_SUB:   state_d = amsc_pkg::ST_SCALE;
      amsc_pkg::ST_SCALE: state_d = amsc_pkg::ST_FIN;
      amsc_pkg::ST_FIN: begin
        if (!side_q) begin
          state_d = amsc_pkg::ST_ABS;
          side_d  = 1'b1;
        end else if (sts_i.out_free) begin
          state_d = amsc_pkg::ST_IDLE;
          side_d  = 1'b0;
        end
      end
      default: state_d = amsc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = amsc_pkg::OP_NONE;
    cmd_o.side = side_q;
    unique case (state_q)
      amsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = amsc_pkg::OP_LOAD;
      end
      amsc_pkg::ST_PROD:  cmd_o.op = amsc_pkg::OP_PROD;
      amsc_pkg::ST_ACC:   cmd_o.op = amsc_pkg::OP_ACC;
      amsc_pkg::ST_ABS:   cmd_o.op = amsc_pkg::OP_ABS;
      amsc_pkg::ST_SQ:    cmd_o.op = amsc_pkg::OP_SQ;
      amsc_pkg::ST_CUBE:  cmd_o.op = amsc_pkg::OP_CUBE;
      amsc_pkg::ST_LIN:   cmd_o.op = amsc_pkg::OP_LIN;
      amsc_pkg::ST_CUB2:  cmd_o.op = amsc_pkg::OP_CUB2;
      amsc_pkg::ST_SUB:   cmd_o.op = amsc_pkg::OP_SUB;
      amsc_pkg::ST_SCALE: cmd_o.op = amsc_pkg::OP_SCALE;
      amsc_pkg::ST_FIN:   cmd_o.op = amsc_pkg::OP_FIN;
      default:            cmd_o.op = amsc_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amsc_pkg::ST_IDLE;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
    end
  end

  // side only flips on leaving the final step
  a_side_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (side_q != $past(side_q)) |-> ($past(state_q) == amsc_pkg::ST_FIN))
    else $error("side changed outside final step");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == amsc_pkg::ST_ACC && !sts_i.last) |=> (state_q == amsc_pkg::ST_IDLE))
    else $error("unmarked word did not return to idle");

endmodule

`default_nettype wire

/* rtl/amsc_dpath.sv */
`default_nettype none

module amsc_dpath #(
  parameter int unsigned CHANNELS = 4
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  amsc_pkg::cmd_t               cmd_i,
  output amsc_pkg::sts_t               sts_o,
  input  amsc_pkg::vol_t [amsc_pkg::NUM_VOLUMES-1:0] vol_i,
  input  wire  [1:0]                   channel_i,
  input  wire  signed [15:0]           left_sample_i,
  input  wire  signed [15:0]           right_sample_i,
  input  wire                          last_channel_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic signed [15:0]           left_out_o,
  output logic signed [15:0]           right_out_o
);

  localparam int unsigned AW = amsc_pkg::ACC_W;

  function automatic logic signed [AW-1:0] sat_add(logic signed [AW-1:0] a,
                                                   logic signed [32:0] b);
    logic signed [AW:0] s;
    s = (AW+1)'(a) + (AW+1)'(b);
    if (s[AW] != s[AW-1]) begin
      return s[AW] ? amsc_pkg::ACC_MIN : amsc_pkg::ACC_MAX;
    end
    return $signed(s[AW-1:0]);
  endfunction

  // item registers
  logic signed [15:0] smp_l_q, smp_l_d, smp_r_q, smp_r_d;
  logic [15:0]        gain_q, gain_d;
  logic               last_q, last_d;
  logic signed [32:0] prod_l_q, prod_l_d, prod_r_q, prod_r_d;
  logic signed [AW-1:0] acc_l_q, acc_l_d, acc_r_q, acc_r_d;

  // clip registers
  logic        neg_q, neg_d, lo_q, lo_d, hi_q, hi_d;
  logic [24:0] m24_q, m24_d;
  logic [26:0] t_q, t_d;
  logic [49:0] a_q, a_d, b_q, b_d;
  logic [15:0] res_l_q, res_l_d;

  logic               out_valid_q, out_valid_d;
  logic signed [15:0] out_l_q, out_l_d, out_r_q, out_r_d;

  logic               chan_en;
  logic signed [AW-1:0] acc_sel;
  logic [AW-1:0]      abs_val;
  logic [26:0]        mul_a;
  logic [24:0]        mul_b;
  logic [51:0]        prod;
  logic [15:0]        mag16;
  logic [15:0]        res;
  logic               out_free;

  assign chan_en  = (32'(channel_i) < 32'(CHANNELS));
  assign out_free = !out_valid_q || out_ready_i;
  assign acc_sel  = cmd_i.side ? acc_r_q : acc_l_q;
  assign abs_val  = acc_sel[AW-1] ? AW'(-acc_sel) : acc_sel;
  assign prod     = 52'(mul_a) * 52'(mul_b);
  assign mag16    = (t_q > 27'(amsc_pkg::CLIP_OUT)) ? amsc_pkg::CLIP_OUT : t_q[15:0];

  always_comb begin
    if (lo_q) begin
      res = 16'd0 - amsc_pkg::CLIP_OUT;
    end else if (hi_q) begin
      res = amsc_pkg::CLIP_OUT;
    end else if (neg_q) begin
      res = 16'd0 - mag16;
    end else begin
      res = mag16;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      amsc_pkg::OP_SQ: begin
        mul_a = {2'b00, m24_q};
        mul_b = m24_q;
      end
      amsc_pkg::OP_CUBE: begin
        mul_a = t_q;
        mul_b = m24_q;
      end
      amsc_pkg::OP_LIN: begin
        mul_a = {2'b00, m24_q};
        mul_b = amsc_pkg::K11;
      end
      amsc_pkg::OP_CUB2: begin
        mul_a = t_q;
        mul_b = amsc_pkg::K02;
      end
      amsc_pkg::OP_SCALE: begin
        mul_a = t_q;
        mul_b = amsc_pkg::FULL_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    smp_l_d     = smp_l_q;
    smp_r_d     = smp_r_q;
    gain_d      = gain_q;
    last_d      = last_q;
    prod_l_d    = prod_l_q;
    prod_r_d    = prod_r_q;
    acc_l_d     = acc_l_q;
    acc_r_d     = acc_r_q;
    neg_d       = neg_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    m24_d       = m24_q;
    t_d         = t_q;
    a_d         = a_q;
    b_d         = b_q;
    res_l_d     = res_l_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    unique case (cmd_i.op)
      amsc_pkg::OP_LOAD: begin
        smp_l_d = left_sample_i;
        smp_r_d = right_sample_i;
        gain_d  = chan_en ? vol_i[channel_i] : 16'd0;
        last_d  = last_channel_i;
      end
      amsc_pkg::OP_PROD: begin
        prod_l_d = 33'(smp_l_q) * $signed({17'd0, gain_q});
        prod_r_d = 33'(smp_r_q) * $signed({17'd0, gain_q});
      end
      amsc_pkg::OP_ACC: begin
        acc_l_d = sat_add(acc_l_q, prod_l_q);
        acc_r_d = sat_add(acc_r_q, prod_r_q);
      end
      amsc_pkg::OP_ABS: begin
        neg_d = acc_sel[AW-1];
        lo_d  = (acc_sel <= amsc_pkg::CLIP_NEG);
        hi_d  = (acc_sel >= amsc_pkg::CLIP_POS);
        m24_d = abs_val[29:5];
      end
      amsc_pkg::OP_SQ:    t_d = prod[50:24];
      amsc_pkg::OP_CUBE:  t_d = prod[50:24];
      amsc_pkg::OP_LIN:   a_d = prod[49:0];
      amsc_pkg::OP_CUB2:  b_d = prod[49:0];
      amsc_pkg::OP_SUB:   t_d = (a_q > b_q) ? 27'((a_q - b_q) >> 24) : 27'd0;
      amsc_pkg::OP_SCALE: t_d = prod[50:24];
      amsc_pkg::OP_FIN: begin
        if (!cmd_i.side) begin
          res_l_d = res;
        end else if (out_free) begin
          out_l_d     = $signed(res_l_q);
          out_r_d     = $signed(res);
          out_valid_d = 1'b1;
          acc_l_d     = '0;
          acc_r_d     = '0;
        end
      end
      default: begin
        t_d = t_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_l_q     <= '0;
      acc_r_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_l_q     <= acc_l_d;
      acc_r_q     <= acc_r_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_l_q  <= smp_l_d;
    smp_r_q  <= smp_r_d;
    gain_q   <= gain_d;
    last_q   <= last_d;
    prod_l_q <= prod_l_d;
    prod_r_q <= prod_r_d;
    neg_q    <= neg_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    m24_q    <= m24_d;
    t_q      <= t_d;
    a_q      <= a_d;
    b_q      <= b_d;
    res_l_q  <= res_l_d;
    out_l_q  <= out_l_d;
    out_r_q  <= out_r_d;
  end

  assign sts_o.last     = last_q;
  assign sts_o.out_free = out_free;
  assign out_valid_o    = out_valid_q;
  assign left_out_o     = out_l_q;
  assign right_out_o    = out_r_q;

  // accumulators start afresh once a frame is handed out
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == amsc_pkg::OP_FIN && cmd_i.side && out_free)
      |=> (acc_l_q == '0 && acc_r_q == '0 && out_valid_q))
    else $error("accumulators not cleared at frame end");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_l_q <= amsc_pkg::OUT_MAX && out_l_q >= amsc_pkg::OUT_MIN &&
                     out_r_q <= amsc_pkg::OUT_MAX && out_r_q >= amsc_pkg::OUT_MIN))
    else $error("clipped word out of range");

endmodule

`default_nettype wire

/* rtl/audio_mix_soft_clip_unit.sv */
// stereo mixer with cubic soft clip
// in_i carries one sample pair word per playing channel: channel index,
// left and right q1.15 samples and a last-channel mark. each pair is weighted
// by that channel's q2.14 volume and summed into saturating 36-bit left and
// right accumulators. a marked word closes the frame: both sums are
// soft-clipped and one word of two signed 16-bit samples leaves on out_o.
// volumes are written over the apb port (volume n at byte address 4*n); the
// user must write them only while the block is idle, as the block itself does
// not enforce it. reads return the stored value. an unmarked word is loaded,
// multiplied and accumulated before the next word is taken. for a marked word
// the clip runs both sides one after the other through a single shared 27x25
// multiplier, eight steps per side. the result waits in an output register;
// when the receiver stalls, input words keep being mixed and only the next
// frame's final step waits for it. reset sets all volumes to unity, clears
// both accumulators and drops out_o.valid.
`default_nettype none

module audio_mix_soft_clip_unit #(
  parameter int unsigned CHANNELS = 4
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  amsc_in_if.sink                   in_i,
  amsc_out_if.source                out_o,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire  [amsc_pkg::PAW-1:0]  paddr,
  input  wire  [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  amsc_pkg::vol_t [amsc_pkg::NUM_VOLUMES-1:0] vol;
  amsc_pkg::cmd_t cmd;
  amsc_pkg::sts_t sts;
  logic           in_ready;

  amsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .vol_o   (vol)
  );

  amsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  amsc_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .vol_i          (vol),
    .channel_i      (in_i.channel),
    .left_sample_i  (in_i.left_sample),
    .right_sample_i (in_i.right_sample),
    .last_channel_i (in_i.last_channel),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .left_out_o     (out_o.left_out),
    .right_out_o    (out_o.right_out)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire
